@@ rtl/core/sevr_pkg.sv @@
// sevr_pkg: types, constants and register indexes of the sensor event reporter.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package sevr_pkg;

	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 72;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	localparam logic [15:0] AGE_MAX           = 16'hFFFF;
	localparam logic [7:0]  FAULT_MOTION_MARK = 8'd254;

	localparam logic [15:0] RST_LUX_THR     = 16'd25;
	localparam logic [14:0] RST_TEMP_THR    = 15'd10;
	localparam logic [15:0] RST_HB_PERIOD   = 16'd30;
	localparam logic [15:0] RST_FAULT_TICKS = 16'd0;
	localparam logic [31:0] RST_ZONE        = 32'd1;
	localparam logic [15:0] RST_LAST_LUX    = 16'd200;
	localparam logic [15:0] RST_LAST_TEMP   = 16'd235;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LUX_THR     = 3'd0,
		REG_TEMP_THR    = 3'd1,
		REG_HB_PERIOD   = 3'd2,
		REG_FAULT_TICKS = 3'd3,
		REG_ZONE        = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		KIND_EVENT = 1'b0,
		KIND_FAULT = 1'b1
	} report_kind_t;

	typedef struct packed {
		logic [15:0] lux_thr;
		logic [14:0] temp_thr;
		logic [15:0] hb_period;
		logic [15:0] fault_ticks;
		logic [31:0] zone;
	} cfg_t;

	typedef struct packed {
		logic        fault;
		logic [15:0] temp;
		logic        motion;
		logic [15:0] lux;
	} sample_t;

	typedef struct packed {
		logic         emit;
		report_kind_t kind;
		logic [15:0]  temp;
		logic [7:0]   motion;
		logic [15:0]  lux;
		logic [31:0]  zone;
	} report_t;

endpackage
`default_nettype wire

@@ rtl/core/sevr_cfg_regs.sv @@
// sevr_cfg_regs: configuration register file of the sensor event reporter.
// Depends on sevr_pkg.
`default_nettype none
module sevr_cfg_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [sevr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [sevr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output sevr_pkg::cfg_t                   cfg
);
	import sevr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lux_thr     <= RST_LUX_THR;
			cfg_q.temp_thr    <= RST_TEMP_THR;
			cfg_q.hb_period   <= RST_HB_PERIOD;
			cfg_q.fault_ticks <= RST_FAULT_TICKS;
			cfg_q.zone        <= RST_ZONE;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				REG_LUX_THR:     cfg_q.lux_thr     <= cfg_data[15:0];
				REG_TEMP_THR:    cfg_q.temp_thr    <= cfg_data[14:0];
				REG_HB_PERIOD:   cfg_q.hb_period   <= cfg_data[15:0];
				REG_FAULT_TICKS: cfg_q.fault_ticks <= cfg_data[15:0];
				REG_ZONE:        cfg_q.zone        <= cfg_data[31:0];
				default: ; // unknown index, write dropped
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sevr_core.sv @@
// sevr_core: per-tick decision logic and tick state (previous samples,
// fault mode, heartbeat and fault ages). Depends on sevr_pkg.
`default_nettype none
module sevr_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 step,
	input  sevr_pkg::sample_t   smp,
	input  sevr_pkg::cfg_t      cfg,
	output sevr_pkg::report_t   rpt
);
	import sevr_pkg::*;

	logic [15:0] last_lux_q;
	logic        last_motion_q;
	logic [15:0] last_temp_q;
	logic        in_fault_q;
	logic [15:0] hb_age_q;
	logic        hb_pending_q;
	logic [15:0] fault_age_q;

	logic [15:0] fa_inc;
	logic        leave_fault;
	logic        active;
	logic [15:0] lux_diff;
	logic [16:0] temp_delta;
	logic [16:0] temp_abs;
	logic        motion_chg;
	logic        lux_chg;
	logic        temp_chg;
	logic        hb_due;
	logic        event_hit;
	logic [15:0] hb_base;

	logic        in_fault_d;
	logic [15:0] fault_age_d;
	logic        hb_pending_d;
	logic [15:0] hb_age_d;

	always_comb begin
		fa_inc      = (fault_age_q == AGE_MAX) ? fault_age_q : fault_age_q + 16'd1;
		leave_fault = in_fault_q && (cfg.fault_ticks != 16'd0) && (fa_inc >= cfg.fault_ticks);
		active      = !in_fault_q || leave_fault;

		lux_diff   = (smp.lux >= last_lux_q) ? smp.lux - last_lux_q : last_lux_q - smp.lux;
		temp_delta = {smp.temp[15], smp.temp} - {last_temp_q[15], last_temp_q};
		temp_abs   = temp_delta[16] ? 17'd0 - temp_delta : temp_delta;

		motion_chg = smp.motion != last_motion_q;
		lux_chg    = lux_diff >= cfg.lux_thr;
		temp_chg   = temp_abs[15:0] >= {1'b0, cfg.temp_thr};
		hb_due     = (cfg.hb_period != 16'd0) && (hb_pending_q || hb_age_q >= cfg.hb_period);
		event_hit  = motion_chg || lux_chg || temp_chg || hb_due;

		// defaults: stay in mode unless leave_fault; fault age follows mode
		in_fault_d   = in_fault_q && !leave_fault;
		fault_age_d  = in_fault_q ? fa_inc : fault_age_q;
		hb_pending_d = hb_pending_q;
		hb_base      = hb_age_q;

		rpt.emit   = 1'b0;
		rpt.kind   = KIND_EVENT;
		rpt.zone   = cfg.zone;
		rpt.lux    = smp.lux;
		rpt.motion = {7'd0, smp.motion};
		rpt.temp   = smp.temp;

		if (active) begin
			if (smp.fault) begin
				in_fault_d  = 1'b1;
				fault_age_d = 16'd0;
				rpt.emit    = 1'b1;
				rpt.kind    = KIND_FAULT;
				rpt.lux     = 16'd0;
				rpt.motion  = FAULT_MOTION_MARK;
				rpt.temp    = 16'd0;
			end else if (event_hit) begin
				rpt.emit = 1'b1;
				if (hb_due) begin
					hb_base      = 16'd0;
					hb_pending_d = 1'b0;
				end
			end
		end

		// heartbeat age advances on every tick, saturating
		hb_age_d = (hb_base == AGE_MAX) ? hb_base : hb_base + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_lux_q    <= RST_LAST_LUX;
			last_motion_q <= 1'b0;
			last_temp_q   <= RST_LAST_TEMP;
			in_fault_q    <= 1'b0;
			hb_age_q      <= 16'd0;
			hb_pending_q  <= 1'b1;
			fault_age_q   <= 16'd0;
		end else if (step) begin
			last_lux_q    <= smp.lux;
			last_motion_q <= smp.motion;
			last_temp_q   <= smp.temp;
			in_fault_q    <= in_fault_d;
			hb_age_q      <= hb_age_d;
			hb_pending_q  <= hb_pending_d;
			fault_age_q   <= fault_age_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/sensor_event_reporter_unit.sv @@
// Sensor event reporter top level: input register, decision logic, result register.
// m_tvalid rises once a tick has passed the input register into the result register.
// Throughput: one tick per cycle; the input stage moves whenever the result register
// is empty or being taken, so the only limit is backpressure on the master side.
// Reset (arst_n low, asynchronous): registers back to defaults, mode ACTIVE, first
// heartbeat due, previous samples lux 200 / motion 0 / temperature 23.5 C, stages empty.
`default_nettype none
module sensor_event_reporter_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// tick input
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// [15:0] lux_sample, [16] motion_sample, [32:17] temp_sample,
	// [33] fault flag, [39:34] zero
	input  wire  [sevr_pkg::IN_TDATA_W-1:0]     s_tdata,
	// report output
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// [31:0] zone_out, [47:32] lux_out, [55:48] motion_out, [71:56] temp_out
	output logic [sevr_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [0] report_kind
	output logic                                m_tuser,
	// configuration writes
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [sevr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [sevr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import sevr_pkg::*;

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	report_t rpt;
	report_t out_q;
	logic    out_valid_q;
	logic    advance;
	logic    load_out;

	sevr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The input stage retires its tick (and commits the tick state) only when the
	// result register can take a report this cycle: empty, or drained by m_tready.
	// Ticks that produce no report retire under the same rule.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign load_out = advance && rpt.emit;

	// Input register: payload needs no reset, only its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			smp_s1.lux    <= s_tdata[15:0];
			smp_s1.motion <= s_tdata[16];
			smp_s1.temp   <= s_tdata[32:17];
			smp_s1.fault  <= s_tdata[33];
		end
	end

	// Decision logic and tick state; state commits with each retired tick.
	sevr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.smp    (smp_s1),
		.cfg    (cfg),
		.rpt    (rpt)
	);

	// Result register: holds a report until the master-side transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= rpt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.temp, out_q.motion, out_q.lux, out_q.zone};

`ifndef SYNTH
	// a fault report carries the fault marker and zeroed samples
	a_fault_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_FAULT) |->
		(m_tdata[55:48] == FAULT_MOTION_MARK && m_tdata[47:32] == 16'd0 &&
		 m_tdata[71:56] == 16'd0))
		else $error("fault report payload malformed");

	// an event report carries a motion value of 0 or 1
	a_event_motion: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_EVENT) |-> (m_tdata[55:49] == 7'd0))
		else $error("event report motion out of range");

	// a held tick in the input stage blocks new input
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while input stage is stalled");

	// a stalled report is not overwritten by a new one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !load_out)
		else $error("result register overwritten while stalled");
`endif

endmodule
`default_nettype wire
